/* sv/dct_pkg.sv */
// ----------------------------------------------------------------------------
// DMA chain tag step package
// Shared widths, tag id codes, register indexes and the structs passed
// between the tag decoder, the return-address stack and the top level.
// ----------------------------------------------------------------------------
package dct_pkg;

  // Return-address stack geometry.
  localparam int unsigned StackDepth = 2;
  localparam int unsigned DepthW     = $clog2(StackDepth + 1);
  localparam int unsigned StackIdxW  = (StackDepth > 1) ? $clog2(StackDepth) : 1;

  // Field widths.
  localparam int unsigned AddrW  = 31;
  localparam int unsigned CountW = 16;
  localparam int unsigned OpW    = 3;
  localparam int unsigned LvlW   = 2;
  localparam int unsigned EntryW = AddrW + 1;

  // Stream payload widths, rounded up to whole bytes.
  localparam int unsigned TdataInW  = 56;
  localparam int unsigned TdataOutW = 88;

  // One quadword in bytes.
  localparam logic [AddrW-1:0] QwBytes = AddrW'(32'h10);

  // Source chain tag ids.
  localparam logic [OpW-1:0] SrcRefe = 3'd0;
  localparam logic [OpW-1:0] SrcCnt  = 3'd1;
  localparam logic [OpW-1:0] SrcNext = 3'd2;
  localparam logic [OpW-1:0] SrcRef  = 3'd3;
  localparam logic [OpW-1:0] SrcRefs = 3'd4;
  localparam logic [OpW-1:0] SrcCall = 3'd5;
  localparam logic [OpW-1:0] SrcRet  = 3'd6;
  localparam logic [OpW-1:0] SrcEnd  = 3'd7;

  // Destination chain tag ids.
  localparam logic [OpW-1:0] DstCnt  = 3'd0;
  localparam logic [OpW-1:0] DstCnts = 3'd1;
  localparam logic [OpW-1:0] DstEnd  = 3'd7;

  // Configuration register indexes (word address bit 2).
  localparam logic RegStartAddr = 1'b0;
  localparam logic RegStartSpr  = 1'b1;

  typedef struct packed {
    logic              is_destination;
    logic [OpW-1:0]    opcode;
    logic [CountW-1:0] tag_count;
    logic [AddrW-1:0]  tag_address;
    logic              tag_scratch;
  } item_t;

  typedef struct packed {
    logic [CountW-1:0] transfer_count;
    logic [AddrW-1:0]  data_addr;
    logic              data_scratch;
    logic [AddrW-1:0]  next_tag_addr;
    logic              next_tag_scratch;
    logic [LvlW-1:0]   stack_level;
    logic              exit_flag;
    logic              stall_flag;
    logic              bad_tag;
  } result_t;

  // Requests from the decoder to the stack.
  typedef struct packed {
    logic              push;
    logic              pop;
    logic [EntryW-1:0] push_data;
  } stk_ctrl_t;

  // Stack status seen by the decoder.
  typedef struct packed {
    logic              full;
    logic              empty;
    logic [DepthW-1:0] depth;
    logic [EntryW-1:0] top;
  } stk_stat_t;

endpackage

/* sv/dma_chain_tag_step.sv */
// ----------------------------------------------------------------------------
// DMA chain tag step
// Decodes one DMA chain tag per beat against a tag pointer and a small
// return-address stack, and reports the packet and the following tag pointer.
// ----------------------------------------------------------------------------
// Usage:
//   Tags arrive as beats on the s_axis channel; s_axis_tuser carries the
//   destination-chain flag and s_axis_tdata the remaining tag fields. Each
//   tag yields exactly one result beat on the m_axis channel, in order;
//   m_axis_tlast is raised on the beat after which the transfer ends.
//   The APB port holds the start tag address (offset 0x0) and the start
//   scratchpad bit (offset 0x4). Writing the address loads the tag pointer
//   and empties the stack; writing the bit loads the pointer's scratchpad
//   bit. Write them only while no tag is in flight.
// Pipeline and throughput:
//   A beat is registered on entry, decoded combinationally from the input
//   register and lands in the result register. One tag is taken every cycle
//   while m_axis_tready stays high; the pointer and stack update in the same
//   cycle as the decode, so back-to-back tags chain correctly.
// Reset:
//   The tag pointer, its scratchpad bit, the stack depth and both stages are
//   cleared. Stack entries are left as they are and are never read unwritten.
// Stall:
//   When m_axis_tready is low the result register holds its beat, the input
//   register fills, and s_axis_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module dma_chain_tag_step
  import dct_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,

  // Tag beats.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [2:0] opcode, [18:3] tag_count, [49:19] tag_address, [50] tag_scratch
  input  logic [TdataInW-1:0]  s_axis_tdata,
  // [0] is_destination
  input  logic                 s_axis_tuser,

  // Result beats.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [15:0] transfer_count, [46:16] data_addr, [47] data_scratch,
  // [78:48] next_tag_addr, [79] next_tag_scratch, [81:80] stack_level,
  // [82] stall_flag, [83] bad_tag
  output logic [TdataOutW-1:0] m_axis_tdata,
  // exit_flag
  output logic                 m_axis_tlast,

  // Configuration port.
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  // Input register stage.
  logic      in_vld_q;
  item_t     in_item_q;
  item_t     in_item_d;

  // Result register stage.
  logic      out_vld_q;
  result_t   out_res_q;

  // Pointer state and configuration registers.
  logic [AddrW-1:0] tag_ptr_q;
  logic             tag_spr_q;
  logic [AddrW-1:0] start_addr_q;
  logic             start_spr_q;

  logic [AddrW-1:0] tag_ptr_d;
  logic             tag_spr_d;
  result_t          res_d;
  stk_ctrl_t        stk_ctrl;
  stk_stat_t        stk_stat;

  logic advance;
  logic in_take;
  logic cfg_wr;
  logic wr_addr;
  logic wr_spr;

  // A tag is decoded when it sits in the input register and the result
  // register is free or being emptied this cycle.
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  assign in_item_d.is_destination = s_axis_tuser;
  assign in_item_d.opcode         = s_axis_tdata[2:0];
  assign in_item_d.tag_count      = s_axis_tdata[18:3];
  assign in_item_d.tag_address    = s_axis_tdata[49:19];
  assign in_item_d.tag_scratch    = s_axis_tdata[50];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_item_d;
    end
  end

  // APB: always ready, register picked by word address bit 2.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign wr_addr = cfg_wr && (paddr[2] == RegStartAddr);
  assign wr_spr  = cfg_wr && (paddr[2] == RegStartSpr);

  always_comb begin
    unique case (paddr[2])
      RegStartAddr: prdata = {1'b0, start_addr_q};
      RegStartSpr:  prdata = {31'b0, start_spr_q};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_addr_q <= '0;
      start_spr_q  <= 1'b0;
      tag_ptr_q    <= '0;
      tag_spr_q    <= 1'b0;
    end else begin
      if (wr_addr) begin
        start_addr_q <= pwdata[AddrW-1:0];
        tag_ptr_q    <= pwdata[AddrW-1:0];
      end else if (advance) begin
        tag_ptr_q <= tag_ptr_d;
      end
      if (wr_spr) begin
        start_spr_q <= pwdata[0];
        tag_spr_q   <= pwdata[0];
      end else if (advance) begin
        tag_spr_q <= tag_spr_d;
      end
    end
  end

  dct_stack u_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (wr_addr),
    .en_i    (advance),
    .ctrl_i  (stk_ctrl),
    .stat_o  (stk_stat)
  );

  dct_decode u_decode (
    .item_i      (in_item_q),
    .tag_ptr_i   (tag_ptr_q),
    .tag_spr_i   (tag_spr_q),
    .stk_i       (stk_stat),
    .res_o       (res_d),
    .tag_ptr_d_o (tag_ptr_d),
    .tag_spr_d_o (tag_spr_d),
    .stk_o       (stk_ctrl)
  );

  // Result register: loads on decode, clears once its beat is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tlast  = out_res_q.exit_flag;
  assign m_axis_tdata  = {4'b0000,
                          out_res_q.bad_tag,
                          out_res_q.stall_flag,
                          out_res_q.stack_level,
                          out_res_q.next_tag_scratch,
                          out_res_q.next_tag_addr,
                          out_res_q.data_scratch,
                          out_res_q.data_addr,
                          out_res_q.transfer_count};

endmodule

/* sv/dct_stack.sv */
// ----------------------------------------------------------------------------
// DMA chain tag return-address stack
// Small register stack with a depth counter; each entry holds the scratchpad
// bit above a 31-bit address. Emptied by a write of the start address.
// ----------------------------------------------------------------------------
module dct_stack
  import dct_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      clear_i,
  input  logic      en_i,
  input  stk_ctrl_t ctrl_i,
  output stk_stat_t stat_o
);

  logic [EntryW-1:0] entry_q [StackDepth];
  logic [DepthW-1:0] depth_q;
  logic [DepthW-1:0] depth_d;
  logic [DepthW-1:0] top_pos;

  assign top_pos = depth_q - DepthW'(1);

  always_comb begin
    depth_d = depth_q;
    if (clear_i) begin
      depth_d = '0;
    end else if (en_i) begin
      depth_d = depth_q + DepthW'(ctrl_i.push) - DepthW'(ctrl_i.pop);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
    end else begin
      depth_q <= depth_d;
    end
  end

  // Entries are only read after being pushed, so they need no reset.
  always_ff @(posedge clk_i) begin
    if (en_i && ctrl_i.push && !clear_i) begin
      entry_q[depth_q[StackIdxW-1:0]] <= ctrl_i.push_data;
    end
  end

  assign stat_o.full  = (depth_q >= DepthW'(StackDepth));
  assign stat_o.empty = (depth_q == '0);
  assign stat_o.depth = depth_q;
  assign stat_o.top   = entry_q[top_pos[StackIdxW-1:0]];

endmodule

/* sv/dct_decode.sv */
// ----------------------------------------------------------------------------
// DMA chain tag decoder
// Combinational step for one tag: works out the packet, the next tag
// pointer, the stack request and the flags from the current pointer state.
// ----------------------------------------------------------------------------
module dct_decode
  import dct_pkg::*;
(
  input  item_t            item_i,
  input  logic [AddrW-1:0] tag_ptr_i,
  input  logic             tag_spr_i,
  input  stk_stat_t        stk_i,
  output result_t          res_o,
  output logic [AddrW-1:0] tag_ptr_d_o,
  output logic             tag_spr_d_o,
  output stk_ctrl_t        stk_o
);

  logic [AddrW-1:0]  after_tag;
  logic [AddrW-1:0]  after_data;
  logic [CountW:0]   qwc_plus;
  logic [CountW-1:0] cnt;
  logic [AddrW-1:0]  daddr;
  logic              dspr;
  logic              ex;
  logic              stall;
  logic              bad;
  logic [DepthW-1:0] depth_after;

  assign after_tag  = tag_ptr_i + QwBytes;
  assign qwc_plus   = {1'b0, item_i.tag_count} + (CountW + 1)'(1);
  assign after_data = tag_ptr_i + AddrW'({qwc_plus, 4'b0000});

  always_comb begin
    cnt            = item_i.tag_count;
    daddr          = after_tag;
    dspr           = tag_spr_i;
    ex             = 1'b0;
    stall          = 1'b0;
    bad            = 1'b0;
    tag_ptr_d_o    = tag_ptr_i;
    tag_spr_d_o    = tag_spr_i;
    stk_o.push      = 1'b0;
    stk_o.pop       = 1'b0;
    stk_o.push_data = {tag_spr_i, after_data};

    if (item_i.is_destination) begin
      daddr = item_i.tag_address;
      dspr  = item_i.tag_scratch;
      unique case (item_i.opcode)
        DstCnt: begin
        end
        DstCnts: begin
          stall = 1'b1;
        end
        DstEnd: begin
          ex = 1'b1;
        end
        default: begin
          // Tag id with no meaning for a destination chain.
          bad   = 1'b1;
          ex    = 1'b1;
          cnt   = '0;
          daddr = '0;
          dspr  = 1'b0;
        end
      endcase
    end else begin
      unique case (item_i.opcode)
        SrcRefe: begin
          daddr       = item_i.tag_address;
          dspr        = item_i.tag_scratch;
          tag_ptr_d_o = after_tag;
          ex          = 1'b1;
        end
        SrcCnt: begin
          tag_ptr_d_o = after_data;
        end
        SrcNext: begin
          tag_ptr_d_o = item_i.tag_address;
          tag_spr_d_o = item_i.tag_scratch;
        end
        SrcRef, SrcRefs: begin
          daddr       = item_i.tag_address;
          dspr        = item_i.tag_scratch;
          tag_ptr_d_o = after_tag;
          stall       = (item_i.opcode == SrcRefs);
        end
        SrcCall: begin
          // On overflow nothing is pushed but the jump still happens.
          if (stk_i.full) begin
            ex = 1'b1;
          end else begin
            stk_o.push = 1'b1;
          end
          tag_ptr_d_o = item_i.tag_address;
          tag_spr_d_o = item_i.tag_scratch;
        end
        SrcRet: begin
          if (stk_i.empty) begin
            ex = 1'b1;
          end else begin
            stk_o.pop   = 1'b1;
            tag_ptr_d_o = stk_i.top[AddrW-1:0];
            tag_spr_d_o = stk_i.top[AddrW];
          end
        end
        SrcEnd: begin
          ex = 1'b1;
        end
      endcase
    end
  end

  assign depth_after = stk_i.depth + DepthW'(stk_o.push) - DepthW'(stk_o.pop);

  assign res_o.transfer_count   = cnt;
  assign res_o.data_addr        = daddr;
  assign res_o.data_scratch     = dspr;
  assign res_o.next_tag_addr    = tag_ptr_d_o;
  assign res_o.next_tag_scratch = tag_spr_d_o;
  assign res_o.stack_level      = LvlW'(depth_after);
  assign res_o.exit_flag        = ex;
  assign res_o.stall_flag       = stall;
  assign res_o.bad_tag          = bad;

endmodule

/* test/tb_dma_chain_tag_step.sv */
// ----------------------------------------------------------------------------
// DMA chain tag step testbench
// Streams source and destination chain tags into the block under several
// start-pointer settings, predicts every result beat with a model of the tag
// pointer and return-address stack, and checks each beat field by field.
// ----------------------------------------------------------------------------
module tb_dma_chain_tag_step;
  import dct_pkg::*;

  // Run control.
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned HoldAt      = 100;
  localparam int unsigned HoldLen     = 200;
  localparam int unsigned PrintLimit  = 50;
  localparam int unsigned IdlePct     = 12;

  // Every input of the block starts from a known value.
  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // [2:0] opcode, [18:3] tag_count, [49:19] tag_address, [50] tag_scratch
  logic [TdataInW-1:0]  s_axis_tdata  = '0;
  // [0] is_destination
  logic                 s_axis_tuser  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // [15:0] transfer_count, [46:16] data_addr, [47] data_scratch,
  // [78:48] next_tag_addr, [79] next_tag_scratch, [81:80] stack_level,
  // [82] stall_flag, [83] bad_tag
  logic [TdataOutW-1:0] m_axis_tdata;
  // [0] exit_flag
  logic                 m_axis_tlast;
  logic                 psel          = 1'b0;
  logic                 penable       = 1'b0;
  logic                 pwrite        = 1'b0;
  logic [2:0]           paddr         = '0;
  logic [31:0]          pwdata        = '0;
  logic [31:0]          prdata;
  logic                 pready;

  dma_chain_tag_step dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  always #4 clk_i = ~clk_i;

  // Tags waiting to be offered, and results the model says must come back.
  item_t       pending_tags[$];
  result_t     expected_results[$];
  item_t       next_tag;
  item_t       seen_tag;
  result_t     want;

  // Model of the block's state: tag pointer, its scratchpad bit and the
  // return-address stack (bit 31 of an entry is the scratchpad bit).
  logic [AddrW-1:0]  ptr_addr  = '0;
  logic              ptr_spr   = 1'b0;
  logic [EntryW-1:0] ret_stack [StackDepth];
  logic [LvlW-1:0]   stk_level = '0;

  // Book-keeping.
  int unsigned tags_queued    = 0;
  int unsigned beats_in       = 0;
  int unsigned beats_out      = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned settings_used  = 1;
  int unsigned n_push = 0, n_pop = 0, n_overflow = 0, n_underflow = 0, n_bad = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  // While calm is set neither side idles, so the block runs at full rate.
  bit          calm      = 1'b0;

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < PrintLimit) $display("MISMATCH: %s", msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (got !== exp_val)
      flag_mismatch($sformatf("result beat %0d, %s: got 0x%0h, expected 0x%0h",
                              beats_out, name, got, exp_val));
  endtask

  // Advances the model by one tag and returns the result beat it must give.
  function automatic result_t chain_step(input item_t t);
    result_t          r;
    logic [AddrW-1:0] after_tag;
    logic [AddrW-1:0] after_data;
    after_tag  = ptr_addr + QwBytes;
    after_data = ptr_addr + AddrW'({t.tag_count, 4'h0}) + QwBytes;
    r = '0;
    r.transfer_count = t.tag_count;
    r.data_addr      = after_tag;
    r.data_scratch   = ptr_spr;
    if (t.is_destination) begin
      // Destination tags never move the pointer; data sits at the tag address.
      r.data_addr    = t.tag_address;
      r.data_scratch = t.tag_scratch;
      case (t.opcode)
        DstCnt:  r.stall_flag = 1'b0;
        DstCnts: r.stall_flag = 1'b1;
        DstEnd:  r.exit_flag  = 1'b1;
        default: begin
          // A tag id with no meaning for this direction: zero packet, exit.
          r.bad_tag        = 1'b1;
          r.exit_flag      = 1'b1;
          r.transfer_count = '0;
          r.data_addr      = '0;
          r.data_scratch   = 1'b0;
          n_bad++;
        end
      endcase
    end else begin
      case (t.opcode)
        SrcRefe: begin
          r.data_addr    = t.tag_address;
          r.data_scratch = t.tag_scratch;
          ptr_addr       = after_tag;
          r.exit_flag    = 1'b1;
        end
        SrcCnt: ptr_addr = after_data;
        SrcNext: begin
          ptr_addr = t.tag_address;
          ptr_spr  = t.tag_scratch;
        end
        SrcRef, SrcRefs: begin
          r.data_addr    = t.tag_address;
          r.data_scratch = t.tag_scratch;
          ptr_addr       = after_tag;
          r.stall_flag   = (t.opcode == SrcRefs);
        end
        SrcCall: begin
          // A full stack takes nothing more, but the jump still happens.
          if (stk_level == LvlW'(StackDepth)) begin
            r.exit_flag = 1'b1;
            n_overflow++;
          end else begin
            ret_stack[stk_level[StackIdxW-1:0]] = {ptr_spr, after_data};
            stk_level++;
            n_push++;
          end
          ptr_addr = t.tag_address;
          ptr_spr  = t.tag_scratch;
        end
        SrcRet: begin
          // Popping an empty stack leaves the pointer alone and ends the run.
          if (stk_level == '0) begin
            r.exit_flag = 1'b1;
            n_underflow++;
          end else begin
            stk_level--;
            {ptr_spr, ptr_addr} = ret_stack[stk_level[StackIdxW-1:0]];
            n_pop++;
          end
        end
        default: r.exit_flag = 1'b1;
      endcase
    end
    r.next_tag_addr    = ptr_addr;
    r.next_tag_scratch = ptr_spr;
    r.stack_level      = stk_level;
    return r;
  endfunction

  function automatic void queue_tag(input logic dst, input logic [OpW-1:0] op,
                                    input logic [CountW-1:0] cnt,
                                    input logic [AddrW-1:0] addr, input logic spr);
    item_t t;
    t.is_destination = dst;
    t.opcode         = op;
    t.tag_count      = cnt;
    t.tag_address    = addr;
    t.tag_scratch    = spr;
    pending_tags.push_back(t);
    tags_queued++;
  endfunction

  // Mostly short packets, with the odd empty or maximal one.
  function automatic logic [CountW-1:0] pick_count();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return CountW'($urandom);
      default: return CountW'($urandom_range(31));
    endcase
  endfunction

  // Quadword-aligned addresses in the main, some close to the top so that the
  // pointer wraps, and some fully random.
  function automatic logic [AddrW-1:0] pick_addr();
    case ($urandom_range(3))
      0:       return AddrW'($urandom) & ~AddrW'(32'hF);
      1:       return AddrW'(32'h7FFF_FF00) | AddrW'($urandom_range(255));
      2:       return AddrW'($urandom_range(4095)) << 4;
      default: return AddrW'($urandom);
    endcase
  endfunction

  // Random traffic: mostly well-formed source chains with nested calls and
  // returns, some destination chains, and a share of arbitrary tags.
  task automatic queue_random(input int unsigned n);
    int unsigned      stop_at;
    int unsigned      len;
    logic [OpW-1:0]   op;
    stop_at = tags_queued + n;
    while (tags_queued < stop_at) begin
      if ($urandom_range(99) < 15) begin
        queue_tag(1'($urandom_range(1)), OpW'($urandom_range(7)), pick_count(),
                  pick_addr(), 1'($urandom_range(1)));
      end else if ($urandom_range(99) < 12) begin
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++)
          queue_tag(1'b1, $urandom_range(1) ? DstCnts : DstCnt, pick_count(),
                    pick_addr(), 1'($urandom_range(1)));
        queue_tag(1'b1, DstEnd, pick_count(), pick_addr(), 1'($urandom_range(1)));
      end else begin
        len = $urandom_range(2, 10);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(9))
            2:       op = SrcNext;
            3:       op = SrcRef;
            4:       op = SrcRefs;
            5, 6:    op = SrcCall;
            7, 8:    op = SrcRet;
            default: op = SrcCnt;
          endcase
          queue_tag(1'b0, op, pick_count(), pick_addr(), 1'($urandom_range(1)));
        end
        queue_tag(1'b0, $urandom_range(1) ? SrcEnd : SrcRefe, pick_count(),
                  pick_addr(), 1'($urandom_range(1)));
      end
    end
  endtask

  // One APB transfer: setup cycle, then access until pready. For a read the
  // returned word is sampled mid-cycle, away from any clock edge.
  task automatic apb_access(input logic wr, input logic [2:0] addr,
                            input logic [31:0] data, input logic [31:0] rd_want);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    if (!wr && prdata !== rd_want)
      flag_mismatch($sformatf("register read at 0x%0h: got 0x%0h, expected 0x%0h",
                              addr, prdata, rd_want));
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Loads a new start pointer. Writing the address also empties the stack.
  task automatic set_start(input bit wr_addr, input logic [31:0] addr_word,
                           input logic [31:0] spr_word);
    if (wr_addr) begin
      apb_access(1'b1, {RegStartAddr, 2'b00}, addr_word, '0);
      ptr_addr  = addr_word[AddrW-1:0];
      stk_level = '0;
      apb_access(1'b0, {RegStartAddr, 2'b00}, '0, {1'b0, addr_word[AddrW-1:0]});
    end
    apb_access(1'b1, {RegStartSpr, 2'b00}, spr_word, '0);
    ptr_spr = spr_word[0];
    apb_access(1'b0, {RegStartSpr, 2'b00}, '0, {31'b0, spr_word[0]});
    settings_used++;
  endtask

  task automatic wait_drained();
    while (beats_out != tags_queued) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Tag sender: a new beat is offered only once the current one is taken.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_tags.size() != 0 && (calm || $urandom_range(99) >= IdlePct)) begin
        next_tag      = pending_tags.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= next_tag.is_destination;
        s_axis_tdata  <= TdataInW'({next_tag.tag_scratch, next_tag.tag_address,
                                    next_tag.tag_count, next_tag.opcode});
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver. Once, after HoldAt tags have gone in, it refuses results
  // until a HoldLen countdown ends while the sender offers, so the block backs up.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && beats_in >= HoldAt) begin
      hold_done     <= 1'b1;
      hold_left     <= HoldLen;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= IdlePct);
    end
  end

  // Every accepted tag beat advances the model and leaves one expectation.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      seen_tag.is_destination = s_axis_tuser;
      seen_tag.opcode         = s_axis_tdata[2:0];
      seen_tag.tag_count      = s_axis_tdata[18:3];
      seen_tag.tag_address    = s_axis_tdata[49:19];
      seen_tag.tag_scratch    = s_axis_tdata[50];
      expected_results.push_back(chain_step(seen_tag));
      beats_in++;
    end
  end

  // Every accepted result beat is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      beats_out++;
      if (expected_results.size() == 0) begin
        flag_mismatch($sformatf("result beat %0d arrived with nothing expected",
                                beats_out));
      end else begin
        want = expected_results.pop_front();
        check_field("transfer_count", 32'(m_axis_tdata[15:0]),
                    32'(want.transfer_count));
        check_field("data_addr", 32'(m_axis_tdata[46:16]), 32'(want.data_addr));
        check_field("data_scratch", 32'(m_axis_tdata[47]), 32'(want.data_scratch));
        check_field("next_tag_addr", 32'(m_axis_tdata[78:48]),
                    32'(want.next_tag_addr));
        check_field("next_tag_scratch", 32'(m_axis_tdata[79]),
                    32'(want.next_tag_scratch));
        check_field("stack_level", 32'(m_axis_tdata[81:80]), 32'(want.stack_level));
        check_field("exit_flag", 32'(m_axis_tlast), 32'(want.exit_flag));
        check_field("stall_flag", 32'(m_axis_tdata[82]), 32'(want.stall_flag));
        check_field("bad_tag", 32'(m_axis_tdata[83]), 32'(want.bad_tag));
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Timed out after %0d cycles with %0d of %0d results seen",
               cycle_count, beats_out, tags_queued);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed tags from the reset pointer (address 0, scratchpad bit 0).
    queue_tag(1'b0, SrcCnt, '0, '0, 1'b0);
    queue_tag(1'b0, SrcCnt, '1, '1, 1'b1);
    queue_tag(1'b0, SrcNext, 16'd3, 31'h7FFF_FFF0, 1'b1);
    // Maximal packet from near the top of memory: the pointer wraps.
    queue_tag(1'b0, SrcCnt, '1, '0, 1'b0);
    queue_tag(1'b0, SrcRef, 16'd5, 31'h1234_5670, 1'b1);
    queue_tag(1'b0, SrcRefs, 16'd7, 31'h0ABC_DEF0, 1'b0);
    // Two nested calls fill the stack; a third overflows it.
    queue_tag(1'b0, SrcCall, 16'd2, 31'h0000_1000, 1'b0);
    queue_tag(1'b0, SrcCall, '1, 31'h7FFF_FFF0, 1'b1);
    queue_tag(1'b0, SrcCall, 16'd1, 31'h0000_3000, 1'b0);
    queue_tag(1'b0, SrcRet, 16'd4, '1, 1'b1);
    queue_tag(1'b0, SrcRet, 16'd0, '0, 1'b0);
    // Return with an empty stack.
    queue_tag(1'b0, SrcRet, 16'd9, 31'h5555_5550, 1'b1);
    queue_tag(1'b0, SrcRefe, 16'd8, 31'h2AAA_AAA0, 1'b1);
    queue_tag(1'b0, SrcEnd, '1, '1, 1'b1);
    queue_tag(1'b1, DstCnt, '1, '1, 1'b1);
    queue_tag(1'b1, DstCnts, '0, '0, 1'b0);
    queue_tag(1'b1, DstEnd, 16'd12, 31'h4000_0000, 1'b1);
    // Destination tag ids that mean nothing.
    for (int op = 2; op <= 6; op++)
      queue_tag(1'b1, OpW'(op), '1, '1, 1'b1);
    queue_tag(1'b0, SrcEnd, '0, '0, 1'b0);
    wait_drained();

    // Start pointer just below the top, scratchpad bit set; bit 31 of the
    // written word must be dropped. The receiver hold-off falls in here.
    set_start(1'b1, 32'hFFFF_FFF0, 32'h0000_0001);
    queue_random(260);
    wait_drained();

    // Highest unaligned start address, no idling on either side.
    calm = 1'b1;
    set_start(1'b1, 32'h7FFF_FFFF, 32'hFFFF_FFFE);
    queue_random(260);
    wait_drained();
    calm = 1'b0;

    set_start(1'b1, $urandom, $urandom);
    queue_random(260);
    wait_drained();

    // Only the scratchpad bit changes: pointer and stack carry over.
    set_start(1'b0, '0, 32'h0000_0001);
    queue_random(260);
    wait_drained();

    // Back to the lowest start pointer.
    set_start(1'b1, 32'h0000_0000, 32'h0000_0000);
    queue_random(260);
    wait_drained();

    $display("Ran %0d tags over %0d start settings, with a %0d-cycle receiver hold-off.",
             beats_in, settings_used, HoldLen);
    $display("Stack: %0d pushes, %0d pops, %0d overflows, %0d underflows; %0d bad tags.",
             n_push, n_pop, n_overflow, n_underflow, n_bad);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results still outstanding",
               mismatch_count, expected_results.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
